// File: design/trace_region_counter_profiler_unit_defines.svh
// assertion macros for the trace region counter profiler
`ifndef TRACE_REGION_COUNTER_PROFILER_UNIT_DEFINES_SVH
`define TRACE_REGION_COUNTER_PROFILER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/trcp_pkg.sv
// shared types and constants of the trace region counter profiler
package trcp_pkg;

	localparam int SLOT_ROOM = 3;
	localparam int IN_W = 192;
	localparam int OUT_W = 384;
	localparam int IDX_W = 3;

	localparam logic [31:0] CTR_LOW = 32'd42000000;
	localparam logic [31:0] CTR_HIGH = 32'd42009998;

	localparam logic [IDX_W-1:0] REG_MATCH_TASK = 3'd0;
	localparam logic [IDX_W-1:0] REG_MATCH_THREAD = 3'd1;
	localparam logic [IDX_W-1:0] REG_WIN_TYPE = 3'd2;
	localparam logic [IDX_W-1:0] REG_WIN_VALUE = 3'd3;
	localparam logic [IDX_W-1:0] REG_SEP_TYPE = 3'd4;
	localparam logic [IDX_W-1:0] REG_CTR_TYPE_0 = 3'd5;
	localparam logic [IDX_W-1:0] REG_CTR_TYPE_1 = 3'd6;
	localparam logic [IDX_W-1:0] REG_CTR_TYPE_2 = 3'd7;

	typedef enum logic [1:0] {
		KIND_ENTER = 2'd0,
		KIND_REGION = 2'd1,
		KIND_EXIT = 2'd2
	} kind_t;

	typedef struct packed {
		logic [15:0] match_task;
		logic [15:0] match_thread;
		logic [31:0] win_type;
		logic [63:0] win_value;
		logic [31:0] sep_type;
		logic [SLOT_ROOM-1:0][31:0] ctr_type;
		logic win_clr;
	} cfg_t;

	typedef struct packed {
		logic [2:0] mask;
		logic [63:0] t_rec;
		logic [63:0] win_start;
		logic [63:0] reg_start;
		logic [63:0] reg_tag;
		logic [SLOT_ROOM-1:0][63:0] sums;
	} grp_t;

endpackage

// File: design/trcp_cfg_regs.sv
// configuration register file
module trcp_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [trcp_pkg::IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data,
	output trcp_pkg::cfg_t cfg
);
	import trcp_pkg::*;

	logic [15:0] match_task_q;
	logic [15:0] match_thread_q;
	logic [31:0] win_type_q;
	logic [63:0] win_value_q;
	logic [31:0] sep_type_q;
	logic [SLOT_ROOM-1:0][31:0] ctr_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_task_q <= '0;
			match_thread_q <= '0;
			win_type_q <= '0;
			win_value_q <= '0;
			sep_type_q <= '0;
			ctr_type_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATCH_TASK: match_task_q <= cfg_data[15:0];
				REG_MATCH_THREAD: match_thread_q <= cfg_data[15:0];
				REG_WIN_TYPE: win_type_q <= cfg_data[31:0];
				REG_WIN_VALUE: win_value_q <= cfg_data;
				REG_SEP_TYPE: sep_type_q <= cfg_data[31:0];
				REG_CTR_TYPE_0: ctr_type_q[0] <= cfg_data[31:0];
				REG_CTR_TYPE_1: ctr_type_q[1] <= cfg_data[31:0];
				REG_CTR_TYPE_2: ctr_type_q[2] <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.match_task = match_task_q;
		cfg.match_thread = match_thread_q;
		cfg.win_type = win_type_q;
		cfg.win_value = win_value_q;
		cfg.sep_type = sep_type_q;
		cfg.ctr_type = ctr_type_q;
		cfg.win_clr = cfg_we && (cfg_index == REG_WIN_TYPE || cfg_index == REG_WIN_VALUE);
	end

endmodule

// File: design/trcp_core.sv
// input register, record gathering, window and region state
`include "trace_region_counter_profiler_unit_defines.svh"
module trcp_core #(
	parameter int COUNTER_SLOTS = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  trcp_pkg::cfg_t cfg,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [trcp_pkg::IN_W-1:0] s_tdata,
	input  logic s_tlast,
	input  logic grp_free,
	output logic grp_load,
	output trcp_pkg::grp_t grp
);
	import trcp_pkg::*;

	logic valid_s1;
	logic [15:0] task_s1;
	logic [15:0] thread_s1;
	logic [63:0] time_s1;
	logic [31:0] type_s1;
	logic [63:0] value_s1;
	logic last_s1;

	logic in_window_q;
	logic window_done_q;
	logic [63:0] window_start_q;
	logic region_open_q;
	logic [63:0] region_start_q;
	logic [63:0] region_tag_q;
	logic [63:0] region_sums_q [COUNTER_SLOTS];
	logic pend_enter_q;
	logic pend_exit_q;
	logic pend_sep_seen_q;
	logic [63:0] pend_sep_value_q;
	logic [63:0] pend_sums_q [COUNTER_SLOTS];

	logic own_hit;
	logic win_hit;
	logic val_eq;
	logic enter_n;
	logic exit_n;
	logic sep_hit;
	logic sep_seen_n;
	logic [63:0] sep_val_n;
	logic in_range;
	logic [COUNTER_SLOTS-1:0] slot_sel;
	logic [63:0] pend_sums_n [COUNTER_SLOTS];
	logic [63:0] region_add [COUNTER_SLOTS];
	logic ent;
	logic act;
	logic open_new;
	logic emit_reg;
	logic emit_exit;
	logic produces;
	logic step;
	logic apply;

	assign step = valid_s1 && (!produces || grp_free);
	assign s_tready = !valid_s1 || step;
	assign apply = step && own_hit && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			task_s1 <= s_tdata[15:0];
			thread_s1 <= s_tdata[31:16];
			time_s1 <= s_tdata[95:32];
			type_s1 <= s_tdata[127:96];
			value_s1 <= s_tdata[191:128];
			last_s1 <= s_tlast;
		end
	end

	// events gathered into the record's pending facts
	always_comb begin
		own_hit = task_s1 == cfg.match_task && thread_s1 == cfg.match_thread;
		win_hit = type_s1 == cfg.win_type;
		val_eq = value_s1 == cfg.win_value;
		enter_n = pend_enter_q | (win_hit & val_eq);
		exit_n = pend_exit_q | (win_hit & !val_eq);
		sep_hit = type_s1 == cfg.sep_type;
		sep_seen_n = pend_sep_seen_q | sep_hit;
		sep_val_n = (sep_hit && !pend_sep_seen_q) ? value_s1 : pend_sep_value_q;
		in_range = type_s1 >= CTR_LOW && type_s1 <= CTR_HIGH;
	end

	// lowest matching slot takes the counter
	always_comb begin
		logic found;
		found = 1'b0;
		for (int s = 0; s < COUNTER_SLOTS; s++) begin
			slot_sel[s] = in_range && !found && cfg.ctr_type[s] == type_s1;
			found = found | slot_sel[s];
		end
	end

	always_comb begin
		for (int s = 0; s < COUNTER_SLOTS; s++) begin
			pend_sums_n[s] = pend_sums_q[s] + (slot_sel[s] ? value_s1 : 64'd0);
			region_add[s] = region_sums_q[s] + pend_sums_n[s];
		end
	end

	// record application
	always_comb begin
		ent = !in_window_q && !window_done_q && enter_n;
		act = (in_window_q || ent) && !window_done_q;
		open_new = act && sep_seen_n && sep_val_n != 64'd0;
		emit_reg = act && !open_new && sep_seen_n && region_open_q;
		emit_exit = act && exit_n;
		produces = own_hit && last_s1 && (ent || emit_reg || emit_exit);
		grp_load = step && produces;
		grp.mask = {emit_exit, emit_reg, ent};
		grp.t_rec = time_s1;
		grp.win_start = ent ? time_s1 : window_start_q;
		grp.reg_start = region_start_q;
		grp.reg_tag = region_tag_q;
		for (int s = 0; s < SLOT_ROOM; s++) begin
			grp.sums[s] = '0;
		end
		for (int s = 0; s < COUNTER_SLOTS; s++) begin
			grp.sums[s] = region_add[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_window_q <= 1'b0;
			window_done_q <= 1'b0;
			window_start_q <= '0;
		end else if (cfg.win_clr) begin
			in_window_q <= 1'b0;
			window_done_q <= 1'b0;
		end else if (apply) begin
			if (ent) begin
				in_window_q <= 1'b1;
				window_start_q <= time_s1;
			end
			if (emit_exit) begin
				window_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_open_q <= 1'b0;
			region_start_q <= '0;
			region_tag_q <= '0;
			for (int s = 0; s < COUNTER_SLOTS; s++) begin
				region_sums_q[s] <= '0;
			end
		end else if (apply && act) begin
			if (open_new) begin
				region_open_q <= 1'b1;
				region_start_q <= time_s1;
				region_tag_q <= sep_val_n;
				for (int s = 0; s < COUNTER_SLOTS; s++) begin
					region_sums_q[s] <= '0;
				end
			end else if (region_open_q) begin
				for (int s = 0; s < COUNTER_SLOTS; s++) begin
					region_sums_q[s] <= region_add[s];
				end
				if (sep_seen_n) begin
					region_open_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_enter_q <= 1'b0;
			pend_exit_q <= 1'b0;
			pend_sep_seen_q <= 1'b0;
			pend_sep_value_q <= '0;
			for (int s = 0; s < COUNTER_SLOTS; s++) begin
				pend_sums_q[s] <= '0;
			end
		end else if (step && own_hit) begin
			if (last_s1) begin
				pend_enter_q <= 1'b0;
				pend_exit_q <= 1'b0;
				pend_sep_seen_q <= 1'b0;
				pend_sep_value_q <= '0;
				for (int s = 0; s < COUNTER_SLOTS; s++) begin
					pend_sums_q[s] <= '0;
				end
			end else begin
				pend_enter_q <= enter_n;
				pend_exit_q <= exit_n;
				pend_sep_seen_q <= sep_seen_n;
				pend_sep_value_q <= sep_val_n;
				for (int s = 0; s < COUNTER_SLOTS; s++) begin
					pend_sums_q[s] <= pend_sums_n[s];
				end
			end
		end
	end

	`ASSERT_IMPL(a_enter_outside, grp_load && grp.mask[0], !in_window_q && !window_done_q)
	`ASSERT_IMPL(a_region_was_open, grp_load && grp.mask[1], region_open_q)
	`ASSERT_NEXT(a_exit_sets_done, grp_load && grp.mask[2] && !cfg.win_clr, window_done_q)

endmodule

// File: design/trcp_out.sv
// result group register and result serializer
`include "trace_region_counter_profiler_unit_defines.svh"
module trcp_out (
	input  logic clk,
	input  logic arst_n,
	input  logic grp_load,
	input  trcp_pkg::grp_t grp,
	output logic grp_free,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [trcp_pkg::OUT_W-1:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic m_tlast
);
	import trcp_pkg::*;

	logic [2:0] mask_q;
	grp_t data_q;
	logic [2:0] cur_bit;
	kind_t kind;
	logic [63:0] t_begin;
	logic [63:0] t_finish;
	logic [63:0] region_value;
	logic [SLOT_ROOM-1:0][63:0] totals;
	logic hs;

	always_comb begin
		if (mask_q[0]) begin
			kind = KIND_ENTER;
			cur_bit = 3'b001;
		end else if (mask_q[1]) begin
			kind = KIND_REGION;
			cur_bit = 3'b010;
		end else begin
			kind = KIND_EXIT;
			cur_bit = 3'b100;
		end
	end

	always_comb begin
		t_begin = '0;
		t_finish = '0;
		region_value = '0;
		totals = '0;
		case (kind)
			KIND_ENTER: begin
				t_begin = data_q.t_rec;
			end
			KIND_REGION: begin
				t_begin = data_q.reg_start;
				t_finish = data_q.t_rec;
				region_value = data_q.reg_tag;
				totals = data_q.sums;
			end
			KIND_EXIT: begin
				t_begin = data_q.win_start;
				t_finish = data_q.t_rec;
			end
			default: ;
		endcase
	end

	assign m_tvalid = mask_q != 3'b000;
	assign m_tlast = (mask_q & ~cur_bit) == 3'b000;
	assign m_tdata = {totals[2], totals[1], totals[0], region_value, t_finish, t_begin};
	assign m_tuser = kind;
	assign hs = m_tvalid && m_tready;
	assign grp_free = !m_tvalid || (hs && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 3'b000;
		end else if (grp_load) begin
			mask_q <= grp.mask;
		end else if (hs) begin
			mask_q <= mask_q & ~cur_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			data_q <= grp;
		end
	end

	`ASSERT_IMPL(a_last_single, m_tvalid && m_tlast, $onehot(mask_q))
	`ASSERT_IMPL(a_load_when_free, grp_load, !m_tvalid || (hs && m_tlast))
	`ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready && !grp_load, $stable(mask_q))

endmodule

// File: design/trace_region_counter_profiler_unit.sv
// trace region counter profiler top level
// a record's last event is held in the input register, then its results go to the result group register
// throughput: one event per cycle, unless a record end with results finds the result side still busy
// with the previous record's results; that record end then waits until the last of them is taken
// results of one record leave one per cycle while m_tready is high, in order enter, region, exit
// reset: arst_n clears configuration, window, region and pending state at once
module trace_region_counter_profiler_unit #(
	parameter int COUNTER_SLOTS = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [trcp_pkg::IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// rec_task, rec_thread, rec_time, ev_type, ev_value
	input  logic [trcp_pkg::IN_W-1:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// t_begin, t_finish, region_value, total_0, total_1, total_2
	output logic [trcp_pkg::OUT_W-1:0] m_tdata,
	// kind
	output logic [1:0] m_tuser,
	output logic m_tlast
);
	import trcp_pkg::*;

	cfg_t cfg;
	grp_t grp;
	logic grp_load;
	logic grp_free;

	trcp_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	trcp_core #(
		.COUNTER_SLOTS(COUNTER_SLOTS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.grp_free(grp_free),
		.grp_load(grp_load),
		.grp(grp)
	);

	trcp_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.grp_load(grp_load),
		.grp(grp),
		.grp_free(grp_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
